// ===== design/assert_macros.svh =====
// Assertion macros used by the top level.
// Each macro takes a label, the clock, the active-low reset, a trigger and a check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check holds in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, trig, chk) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (chk)) \
		else $error("assertion failed");

// check holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, chk) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (chk)) \
		else $error("assertion failed");

`endif

// ===== design/sob_pkg.sv =====
// Shared types, codes and helpers of the skeleton oriented box.
// Used by sob_ctrl, sob_dp and the top level.
package sob_pkg;

	localparam int CoordW = 24;
	localparam int UpW    = 16;
	localparam int RadW   = 20;
	localparam int IdxW   = 5;
	localparam int KindW  = 3;
	localparam int CfgIdxW = 3;
	localparam int AxW    = 18;
	localparam int ProjW  = 32;
	localparam int MulW   = 32;
	localparam int ProdW  = 64;
	localparam int ItW    = 5;
	localparam int WordW  = 3 * CoordW;

	localparam logic [ItW-1:0] SqrtLast = ItW'(31);
	localparam logic [ItW-1:0] DivLast  = ItW'(15);

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] REG_UP_X      = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_UP_Y      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_UP_Z      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_RADIUS    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LEFT_SH   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_RIGHT_SH  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_CENTER_SH = 3'd6;

	// result kinds
	localparam logic [KindW-1:0] KIND_CENTER = 3'd0;
	localparam logic [KindW-1:0] KIND_AXIS0  = 3'd1;
	localparam logic [KindW-1:0] KIND_AXIS1  = 3'd2;
	localparam logic [KindW-1:0] KIND_AXIS2  = 3'd3;
	localparam logic [KindW-1:0] KIND_SIZE   = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_L, ST_RD_R, ST_RD_C, ST_CAP_C,
		ST_DOT, ST_DOTSUM, ST_UPL, ST_UPH, ST_H,
		ST_NORM, ST_SQ, ST_SUM, ST_SQRT,
		ST_DIV_INIT, ST_DIV, ST_DIV_END,
		ST_CROSS1, ST_CROSS2, ST_AX2,
		ST_P_RD, ST_P_R, ST_P_MUL, ST_P_RED,
		ST_WIDEN, ST_C_MUL, ST_C_RED, ST_EMIT
	} state_t;

	typedef struct packed {
		state_t           op;
		logic [1:0]       lane;
		logic             first;
		logic             mem_we;
		logic             load_out;
		logic [KindW-1:0] kind;
	} cmd_t;

	function automatic logic signed [CoordW-1:0] sat24(input logic signed [ProdW-1:0] v);
		if (v > 64'sd8388607) return 24'sh7FFFFF;
		if (v < -64'sd8388608) return 24'sh800000;
		return v[CoordW-1:0];
	endfunction

endpackage

// ===== design/skeleton_oriented_box.sv =====
// Oriented box of one skeleton frame. A frame is JOINTS input words, one joint
// each, taken one per cycle while the block is loading. After the last joint
// the block is busy (projection walk over the joint memory through the
// shared three-lane multiplier, bit-serial square root, three divisions,
// up to 17 normalizing shifts), then emits five words: center, axis0, axis1,
// axis2, size; tlast marks the size word. The next frame may load while the
// last word still waits in the output register.
// Depends on sob_pkg, sob_ctrl, sob_dp and assert_macros.svh.
`include "assert_macros.svh"

module skeleton_oriented_box import sob_pkg::*; #(
	parameter int JOINTS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [WordW-1:0]   s_tdata,    // joint_x, joint_y, joint_z
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [WordW-1:0]   m_tdata,    // out_x, out_y, out_z
	output logic [3:0]         m_tuser,    // vector_kind[2:0], degenerate
	output logic               m_tlast,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [RadW-1:0]    cfg_data
);

	localparam int AW = $clog2(JOINTS);

	cmd_t          cmd;
	logic [AW-1:0] idx;
	logic          norm_high;
	logic [KindW-1:0] out_kind;
	logic          out_deg;

	assign cfg_ready = 1'b1;
	assign m_tuser   = {out_deg, out_kind};

	sob_ctrl #(.JOINTS(JOINTS), .AW(AW)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.norm_high (norm_high),
		.cmd       (cmd),
		.idx       (idx)
	);

	sob_dp #(.JOINTS(JOINTS), .AW(AW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.norm_high (norm_high),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (s_tdata),
		.out_word  (m_tdata),
		.out_kind  (out_kind),
		.out_deg   (out_deg),
		.out_last  (m_tlast)
	);

	`ASSERT_SAME(a_last_on_size, clk, arst_n, m_tvalid && m_tlast, m_tuser[2:0] == KIND_SIZE)
	`ASSERT_SAME(a_deg_axis0, clk, arst_n, m_tvalid && m_tuser[3] && m_tuser[2:0] == KIND_AXIS0, m_tdata == '0)
	`ASSERT_SAME(a_deg_axis2, clk, arst_n, m_tvalid && m_tuser[3] && m_tuser[2:0] == KIND_AXIS2, m_tdata == '0)
	`ASSERT_NEXT(a_frame_burst, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

// ===== design/sob_ctrl.sv =====
// Sequencer of the skeleton oriented box: load, solve, project and emit phases.
// Depends on sob_pkg; drives sob_dp through cmd_t.
module sob_ctrl import sob_pkg::*; #(
	parameter int JOINTS = 20,
	parameter int AW     = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          m_tready,
	output logic          m_tvalid,
	input  logic          norm_high,
	output cmd_t          cmd,
	output logic [AW-1:0] idx
);

	localparam logic [AW-1:0] LastIdx = AW'(JOINTS - 1);

	state_t           state_q, state_d;
	logic [AW-1:0]    cnt_q, j_q;
	logic [1:0]       k_q;
	logic [ItW-1:0]   it_q;
	logic [KindW-1:0] emit_q;
	logic             ovalid_q;
	logic             load;

	assign load = (state_q == ST_EMIT) && (!ovalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid && cnt_q == LastIdx) state_d = ST_RD_L;
			ST_RD_L:     state_d = ST_RD_R;
			ST_RD_R:     state_d = ST_RD_C;
			ST_RD_C:     state_d = ST_CAP_C;
			ST_CAP_C:    state_d = ST_DOT;
			ST_DOT:      state_d = ST_DOTSUM;
			ST_DOTSUM:   state_d = ST_UPL;
			ST_UPL:      state_d = ST_UPH;
			ST_UPH:      state_d = ST_H;
			ST_H:        state_d = ST_NORM;
			ST_NORM:     if (!norm_high) state_d = ST_SQ;
			ST_SQ:       state_d = ST_SUM;
			ST_SUM:      state_d = ST_SQRT;
			ST_SQRT:     if (it_q == SqrtLast) state_d = ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV:      if (it_q == DivLast) state_d = ST_DIV_END;
			ST_DIV_END:  state_d = (k_q == 2'd2) ? ST_CROSS1 : ST_DIV_INIT;
			ST_CROSS1:   state_d = ST_CROSS2;
			ST_CROSS2:   state_d = ST_AX2;
			ST_AX2:      state_d = ST_P_RD;
			ST_P_RD:     state_d = ST_P_R;
			ST_P_R:      state_d = ST_P_MUL;
			ST_P_MUL:    state_d = ST_P_RED;
			ST_P_RED: begin
				if (k_q != 2'd2) state_d = ST_P_MUL;
				else if (j_q == LastIdx) state_d = ST_WIDEN;
				else state_d = ST_P_RD;
			end
			ST_WIDEN:    state_d = ST_C_MUL;
			ST_C_MUL:    state_d = ST_C_RED;
			ST_C_RED:    state_d = (k_q == 2'd2) ? ST_EMIT : ST_C_MUL;
			ST_EMIT:     if (load && emit_q == KIND_SIZE) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op       = state_q;
		cmd.lane     = k_q;
		cmd.first    = (j_q == '0);
		cmd.mem_we   = (state_q == ST_IDLE) && s_tvalid;
		cmd.load_out = load;
		cmd.kind     = emit_q;
		idx          = (state_q == ST_IDLE) ? cnt_q : j_q;
		s_tready     = (state_q == ST_IDLE);
		m_tvalid     = ovalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			j_q      <= '0;
			k_q      <= '0;
			it_q     <= '0;
			emit_q   <= KIND_CENTER;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) ovalid_q <= 1'b1;
			else if (m_tready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid) cnt_q <= (cnt_q == LastIdx) ? '0 : cnt_q + 1'b1;
				ST_SUM:      it_q <= '0;
				ST_SQRT: begin
					it_q <= it_q + 1'b1;
					k_q  <= '0;
				end
				ST_DIV_INIT: it_q <= '0;
				ST_DIV:      it_q <= it_q + 1'b1;
				ST_DIV_END:  k_q <= k_q + 1'b1;
				ST_AX2:      j_q <= '0;
				ST_P_R:      k_q <= '0;
				ST_P_RED: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
					if (k_q == 2'd2) j_q <= j_q + 1'b1;
				end
				ST_WIDEN:    k_q <= '0;
				ST_C_RED:    k_q <= k_q + 1'b1;
				ST_EMIT: if (load) emit_q <= (emit_q == KIND_SIZE) ? KIND_CENTER : emit_q + 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/sob_dp.sv =====
// Datapath of the skeleton oriented box: joint memory, config registers,
// three multiplier lanes, bit-serial square root and divider, min/max tracking.
// Depends on sob_pkg; steered by sob_ctrl.
module sob_dp import sob_pkg::*; #(
	parameter int JOINTS = 20,
	parameter int AW     = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [AW-1:0]      idx,
	output logic               norm_high,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [RadW-1:0]    cfg_data,
	input  logic [WordW-1:0]   in_word,
	output logic [WordW-1:0]   out_word,
	output logic [KindW-1:0]   out_kind,
	output logic               out_deg,
	output logic               out_last
);

	logic signed [UpW-1:0]    up_q [3];
	logic [RadW-1:0]          rad_q;
	logic [IdxW-1:0]          li_q, ri_q, ci_q;

	logic [WordW-1:0]         jmem [JOINTS];
	logic [WordW-1:0]         rdata_q;
	logic [AW-1:0]            addr;

	logic signed [CoordW-1:0] lv_q [3], c_q [3], cen_q [3], rfield [3];
	logic signed [CoordW:0]   d_q [3], r_q [3];
	logic signed [44:0]       dot_q;
	logic signed [MulW-1:0]   mul_a [3], mul_b [3];
	logic signed [ProdW-1:0]  prod_q [3], hold_q [3], psum, full_c [3], rup_c [3];
	logic signed [47:0]       h_c [3];
	logic [46:0]              m_q [3];
	logic                     hneg_q [3];
	logic                     deg_q;
	logic [62:0]              sq_n_q, sq_r_q, sq_bit_q, sq_t;
	logic [30:0]              len;
	logic [44:0]              num_c;
	logic [31:0]              rem_q;
	logic [32:0]              rem2;
	logic [15:0]              num_q, quo_q;
	logic signed [AxW-1:0]    a0_q [3], a2_q [3], axk [3];
	logic signed [ProjW-1:0]  pmin_q [3], pmax_q [3], ssum [3], proj, rad32;
	logic signed [ProdW-1:0]  diff_c [3];

	function automatic logic [AW-1:0] clamp_idx(input logic [IdxW-1:0] v);
		if (int'(v) >= JOINTS) return AW'(JOINTS - 1);
		return v[AW-1:0];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q[0] <= 16'sd0;
			up_q[1] <= 16'sd0;
			up_q[2] <= 16'sd16384;
			rad_q   <= 20'd4096;
			li_q    <= 5'd4;
			ri_q    <= 5'd8;
			ci_q    <= 5'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UP_X:      up_q[0] <= cfg_data[UpW-1:0];
				REG_UP_Y:      up_q[1] <= cfg_data[UpW-1:0];
				REG_UP_Z:      up_q[2] <= cfg_data[UpW-1:0];
				REG_RADIUS:    rad_q   <= cfg_data;
				REG_LEFT_SH:   li_q    <= cfg_data[IdxW-1:0];
				REG_RIGHT_SH:  ri_q    <= cfg_data[IdxW-1:0];
				REG_CENTER_SH: ci_q    <= cfg_data[IdxW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.op)
			ST_RD_L: addr = clamp_idx(li_q);
			ST_RD_R: addr = clamp_idx(ri_q);
			ST_RD_C: addr = clamp_idx(ci_q);
			default: addr = idx;
		endcase
	end

	// joint memory, one word per joint, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we) jmem[addr] <= in_word;
		rdata_q <= jmem[addr];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rfield[i] = rdata_q[CoordW*i +: CoordW];
			case (cmd.lane)
				2'd0:    axk[i] = a0_q[i];
				2'd1:    axk[i] = AxW'(up_q[i]);
				default: axk[i] = a2_q[i];
			endcase
			full_c[i] = (prod_q[i] <<< 22) + hold_q[i];
			rup_c[i]  = (full_c[i] + 64'sd8192) >>> 14;
			h_c[i]    = 48'((ProdW'(d_q[i]) <<< 14) - rup_c[i]);
			diff_c[i] = hold_q[i] - prod_q[i];
			ssum[i]   = pmin_q[i] + pmax_q[i];
		end
		psum      = prod_q[0] + prod_q[1] + prod_q[2];
		proj      = ProjW'((psum + 64'sd8192) >>> 14);
		rad32     = $signed(ProjW'(rad_q));
		norm_high = |(m_q[0][46:30] | m_q[1][46:30] | m_q[2][46:30]);
		sq_t      = sq_r_q + sq_bit_q;
		len       = sq_r_q[30:0];
		num_c     = 45'({m_q[cmd.lane][29:0], 14'd0}) + 45'(sq_r_q[30:1]);
		rem2      = {rem_q, num_q[15]};
	end

	// multiplier lane operands
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mul_a[i] = '0;
			mul_b[i] = '0;
		end
		case (cmd.op)
			ST_DOT: for (int i = 0; i < 3; i++) begin
				mul_a[i] = MulW'(up_q[i]);
				mul_b[i] = MulW'(d_q[i]);
			end
			ST_UPL: for (int i = 0; i < 3; i++) begin
				mul_a[i] = MulW'(up_q[i]);
				mul_b[i] = MulW'({1'b0, dot_q[21:0]});
			end
			ST_UPH: for (int i = 0; i < 3; i++) begin
				mul_a[i] = MulW'(up_q[i]);
				mul_b[i] = MulW'(dot_q >>> 22);
			end
			ST_SQ: for (int i = 0; i < 3; i++) begin
				mul_a[i] = MulW'({2'b0, m_q[i][29:0]});
				mul_b[i] = MulW'({2'b0, m_q[i][29:0]});
			end
			ST_CROSS1: begin
				mul_a[0] = MulW'(a0_q[1]); mul_b[0] = MulW'(up_q[2]);
				mul_a[1] = MulW'(a0_q[2]); mul_b[1] = MulW'(up_q[0]);
				mul_a[2] = MulW'(a0_q[0]); mul_b[2] = MulW'(up_q[1]);
			end
			ST_CROSS2: begin
				mul_a[0] = MulW'(a0_q[2]); mul_b[0] = MulW'(up_q[1]);
				mul_a[1] = MulW'(a0_q[0]); mul_b[1] = MulW'(up_q[2]);
				mul_a[2] = MulW'(a0_q[1]); mul_b[2] = MulW'(up_q[0]);
			end
			ST_P_MUL: for (int i = 0; i < 3; i++) begin
				mul_a[i] = MulW'(r_q[i]);
				mul_b[i] = MulW'(axk[i]);
			end
			ST_C_MUL: begin
				mul_a[0] = MulW'(a0_q[cmd.lane]); mul_b[0] = ssum[0];
				mul_a[1] = MulW'(up_q[cmd.lane]); mul_b[1] = ssum[1];
				mul_a[2] = MulW'(a2_q[cmd.lane]); mul_b[2] = ssum[2];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) prod_q[i] <= mul_a[i] * mul_b[i];
		case (cmd.op)
			ST_RD_R: for (int i = 0; i < 3; i++) lv_q[i] <= rfield[i];
			ST_RD_C: for (int i = 0; i < 3; i++)
				d_q[i] <= (CoordW+1)'(lv_q[i]) - (CoordW+1)'(rfield[i]);
			ST_CAP_C: for (int i = 0; i < 3; i++) c_q[i] <= rfield[i];
			ST_DOTSUM: dot_q <= psum[44:0];
			ST_UPH: for (int i = 0; i < 3; i++) hold_q[i] <= prod_q[i];
			ST_H: begin
				for (int i = 0; i < 3; i++) begin
					hneg_q[i] <= h_c[i][47];
					m_q[i]    <= h_c[i][47] ? 47'(-h_c[i]) : h_c[i][46:0];
				end
				deg_q <= (h_c[0] == '0) && (h_c[1] == '0) && (h_c[2] == '0);
			end
			// one shift per cycle until every magnitude is below 2^30
			ST_NORM: if (norm_high) for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
			ST_SUM: begin
				sq_n_q   <= psum[62:0];
				sq_r_q   <= '0;
				sq_bit_q <= 63'h4000_0000_0000_0000;
			end
			// one result bit per cycle
			ST_SQRT: begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			// quotient stays below 2^16, so the top of the numerator starts the remainder
			ST_DIV_INIT: begin
				rem_q <= 32'(num_c[44:16]);
				num_q <= num_c[15:0];
				quo_q <= '0;
			end
			ST_DIV: begin
				if (rem2 >= {2'b0, len}) rem_q <= 32'(rem2 - {2'b0, len});
				else rem_q <= rem2[31:0];
				quo_q <= {quo_q[14:0], rem2 >= {2'b0, len}};
				num_q <= num_q << 1;
			end
			ST_DIV_END: begin
				if (deg_q) a0_q[cmd.lane] <= '0;
				else if (hneg_q[cmd.lane]) a0_q[cmd.lane] <= -AxW'({1'b0, quo_q});
				else a0_q[cmd.lane] <= AxW'({1'b0, quo_q});
			end
			ST_CROSS2: for (int i = 0; i < 3; i++) hold_q[i] <= prod_q[i];
			ST_AX2: for (int i = 0; i < 3; i++)
				a2_q[i] <= AxW'((diff_c[i] + 64'sd8192) >>> 14);
			ST_P_R: for (int i = 0; i < 3; i++)
				r_q[i] <= (CoordW+1)'(rfield[i]) - (CoordW+1)'(c_q[i]);
			ST_P_RED: begin
				if (cmd.first || proj < pmin_q[cmd.lane]) pmin_q[cmd.lane] <= proj;
				if (cmd.first || proj > pmax_q[cmd.lane]) pmax_q[cmd.lane] <= proj;
			end
			// up axis gets three radii on top
			ST_WIDEN: for (int i = 0; i < 3; i++) begin
				pmin_q[i] <= pmin_q[i] - rad32;
				pmax_q[i] <= pmax_q[i] + ((i == 1) ? (rad32 <<< 1) + rad32 : rad32);
			end
			ST_C_RED: cen_q[cmd.lane] <=
				sat24(ProdW'(c_q[cmd.lane]) + ((psum + 64'sd16384) >>> 15));
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_kind <= cmd.kind;
			out_deg  <= deg_q;
			out_last <= (cmd.kind == KIND_SIZE);
			case (cmd.kind)
				KIND_CENTER: out_word <= {cen_q[2], cen_q[1], cen_q[0]};
				KIND_AXIS0:  out_word <= {CoordW'(a0_q[2]), CoordW'(a0_q[1]), CoordW'(a0_q[0])};
				KIND_AXIS1:  out_word <= {CoordW'(up_q[2]), CoordW'(up_q[1]), CoordW'(up_q[0])};
				KIND_AXIS2:  out_word <= {CoordW'(a2_q[2]), CoordW'(a2_q[1]), CoordW'(a2_q[0])};
				default: out_word <= {
					sat24(ProdW'(pmax_q[2]) - ProdW'(pmin_q[2])),
					sat24(ProdW'(pmax_q[1]) - ProdW'(pmin_q[1])),
					sat24(ProdW'(pmax_q[0]) - ProdW'(pmin_q[0]))};
			endcase
		end
	end

endmodule
